@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");

// next-cycle implication
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");

`endif

@@ sv/wss_pkg.sv @@
// ----------------------------------------------------------------------------
// wss_pkg
// shared constants for the windowed sample statistics block
// ----------------------------------------------------------------------------
`default_nettype none

package wss_pkg;

    localparam int SAMPLE_WIDTH_DEF       = 16;
    localparam int WINDOW_COUNT_WIDTH_DEF = 16;
    localparam int QUEUE_DEPTH_DEF        = 2;

    localparam int CFG_WIDTH = 16;
    localparam logic [CFG_WIDTH-1:0] WINDOW_LENGTH_RESET = 16'd16;

endpackage

`default_nettype wire

@@ sv/windowed_sample_statistics.sv @@
// ----------------------------------------------------------------------------
// windowed_sample_statistics: per-window mean, minimum, maximum and std dev
// throughput: one sample per cycle; stalls only when a window closes on a full queue
// back end: one window at a time; sum squared, times count, divides and square root in turn
// reset (sync, active low): clears position, queue, output valid; length back to 16
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module windowed_sample_statistics #(
    parameter int SAMPLE_WIDTH       = wss_pkg::SAMPLE_WIDTH_DEF,
    parameter int WINDOW_COUNT_WIDTH = wss_pkg::WINDOW_COUNT_WIDTH_DEF,
    parameter int QUEUE_DEPTH        = wss_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [wss_pkg::CFG_WIDTH-1:0]     cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]    s_sample,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [SAMPLE_WIDTH-1:0]    m_mean,
    output logic signed [SAMPLE_WIDTH-1:0]    m_minimum,
    output logic signed [SAMPLE_WIDTH-1:0]    m_maximum,
    output logic [SAMPLE_WIDTH-1:0]           m_std_dev
);

    import wss_pkg::*;

    localparam int SW   = SAMPLE_WIDTH;
    localparam int CW   = WINDOW_COUNT_WIDTH;
    localparam int SUMW = SW + CW;
    localparam int SQW  = 2 * SW + CW - 2;
    localparam int FW   = SUMW + SQW + 2 * SW + CW;

    logic                   q_push, q_pop, q_full, q_empty;
    logic signed [SUMW-1:0] rec_sum, q_sum;
    logic [SQW-1:0]         rec_sumsq, q_sumsq;
    logic signed [SW-1:0]   rec_min, rec_max, q_min, q_max;
    logic [CW-1:0]          rec_count, q_count;
    logic [FW-1:0]          q_din, q_dout;

    wss_front #(
        .SAMPLE_WIDTH       (SAMPLE_WIDTH),
        .WINDOW_COUNT_WIDTH (WINDOW_COUNT_WIDTH)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample    (s_sample),
        .q_full      (q_full),
        .q_push      (q_push),
        .rec_sum     (rec_sum),
        .rec_sumsq   (rec_sumsq),
        .rec_min     (rec_min),
        .rec_max     (rec_max),
        .rec_count   (rec_count)
    );

    assign q_din = {rec_sum, rec_sumsq, rec_min, rec_max, rec_count};

    wss_fifo #(
        .WIDTH (FW),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (q_din),
        .pop     (q_pop),
        .dout    (q_dout),
        .full    (q_full),
        .empty   (q_empty)
    );

    assign q_count = q_dout[CW-1:0];
    assign q_max   = q_dout[CW +: SW];
    assign q_min   = q_dout[CW+SW +: SW];
    assign q_sumsq = q_dout[CW+2*SW +: SQW];
    assign q_sum   = q_dout[CW+2*SW+SQW +: SUMW];

    wss_back #(
        .SAMPLE_WIDTH       (SAMPLE_WIDTH),
        .WINDOW_COUNT_WIDTH (WINDOW_COUNT_WIDTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (!q_empty),
        .q_pop     (q_pop),
        .q_sum     (q_sum),
        .q_sumsq   (q_sumsq),
        .q_min     (q_min),
        .q_max     (q_max),
        .q_count   (q_count),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_mean    (m_mean),
        .m_minimum (m_minimum),
        .m_maximum (m_maximum),
        .m_std_dev (m_std_dev)
    );

    // closing a window never pushes into a full queue
    `ASSERT_IMP(a_push_has_room, aclk, aresetn, q_push, !q_full)
    // back end only takes a record that is there
    `ASSERT_IMP(a_pop_has_entry, aclk, aresetn, q_pop, !q_empty)
    // a pushed record is visible to the back end on the next cycle
    `ASSERT_NXT(a_push_lands, aclk, aresetn, q_push, !q_empty)

endmodule

`default_nettype wire

@@ sv/wss_fifo.sv @@
// ----------------------------------------------------------------------------
// wss_fifo
// short register queue of closed-window records between front and back end
// ----------------------------------------------------------------------------
`default_nettype none

module wss_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = wss_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             full,
    output logic             empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]    cnt_reg, cnt_next;

    always_comb begin
        full        = (cnt_reg == NW'(DEPTH));
        empty       = (cnt_reg == '0);
        dout        = mem_reg[rd_ptr_reg];
        wr_ptr_next = push ? ((wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1))
                           : wr_ptr_reg;
        rd_ptr_next = pop ? ((rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1))
                          : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   cnt_next = cnt_reg + NW'(1);
            2'b01:   cnt_next = cnt_reg - NW'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

`default_nettype wire

@@ sv/wss_front.sv @@
// ----------------------------------------------------------------------------
// wss_front
// window length register, per-sample accumulation and window close detection
// ----------------------------------------------------------------------------
`default_nettype none

module wss_front #(
    parameter int SAMPLE_WIDTH       = wss_pkg::SAMPLE_WIDTH_DEF,
    parameter int WINDOW_COUNT_WIDTH = wss_pkg::WINDOW_COUNT_WIDTH_DEF
) (
    input  logic                                              aclk,
    input  logic                                              aresetn,
    input  logic                                              cfg_wr_en,
    input  logic [wss_pkg::CFG_WIDTH-1:0]                     cfg_wr_data,
    input  logic                                              s_valid,
    output logic                                              s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]                    s_sample,
    input  logic                                              q_full,
    output logic                                              q_push,
    output logic signed [SAMPLE_WIDTH+WINDOW_COUNT_WIDTH-1:0] rec_sum,
    output logic [2*SAMPLE_WIDTH+WINDOW_COUNT_WIDTH-3:0]      rec_sumsq,
    output logic signed [SAMPLE_WIDTH-1:0]                    rec_min,
    output logic signed [SAMPLE_WIDTH-1:0]                    rec_max,
    output logic [WINDOW_COUNT_WIDTH-1:0]                     rec_count
);

    import wss_pkg::*;

    localparam int SW   = SAMPLE_WIDTH;
    localparam int CW   = WINDOW_COUNT_WIDTH;
    localparam int SUMW = SW + CW;
    localparam int SQW  = 2 * SW + CW - 2;
    localparam int LW   = (CW > CFG_WIDTH) ? CW : CFG_WIDTH;

    // zero length means one, lengths beyond the counter saturate
    function automatic logic [CW-1:0] clamp_len(input logic [CFG_WIDTH-1:0] raw);
        logic [LW-1:0] raw_ext;
        logic [LW-1:0] max_ext;
        raw_ext = LW'(raw);
        max_ext = LW'({CW{1'b1}});
        if (raw_ext == '0) begin
            clamp_len = CW'(1);
        end else if (raw_ext > max_ext) begin
            clamp_len = {CW{1'b1}};
        end else begin
            clamp_len = CW'(raw_ext);
        end
    endfunction

    logic [CW-1:0]          len_reg, len_next;
    logic [CW-1:0]          pos_reg, pos_next, pos_inc;
    logic signed [SUMW-1:0] sum_reg, sum_next, sum_base;
    logic [SQW-1:0]         sq_reg, sq_next, sq_base, sq_term;
    logic signed [SW-1:0]   min_reg, min_next, max_reg, max_next;
    logic signed [2*SW-1:0] prod;
    logic                   first, close, accept;

    always_comb begin
        first    = (pos_reg == '0);
        pos_inc  = pos_reg + CW'(1);
        close    = (pos_inc >= len_reg);
        s_ready  = !q_full || !close;
        accept   = s_valid && s_ready;
        q_push   = accept && close;

        prod     = s_sample * s_sample;
        sq_term  = {{(CW-1){1'b0}}, prod[2*SW-2:0]};
        sum_base = first ? '0 : sum_reg;
        sq_base  = first ? '0 : sq_reg;
        sum_next = sum_base + {{CW{s_sample[SW-1]}}, s_sample};
        sq_next  = sq_base + sq_term;
        min_next = (first || (s_sample < min_reg)) ? s_sample : min_reg;
        max_next = (first || (s_sample > max_reg)) ? s_sample : max_reg;

        pos_next = accept ? (close ? '0 : pos_inc) : pos_reg;
        len_next = cfg_wr_en ? clamp_len(cfg_wr_data) : len_reg;

        rec_sum   = sum_next;
        rec_sumsq = sq_next;
        rec_min   = min_next;
        rec_max   = max_next;
        rec_count = pos_inc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= clamp_len(WINDOW_LENGTH_RESET);
            pos_reg <= '0;
        end else begin
            len_reg <= len_next;
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            sum_reg <= sum_next;
            sq_reg  <= sq_next;
            min_reg <= min_next;
            max_reg <= max_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/wss_back.sv @@
// ----------------------------------------------------------------------------
// wss_back
// per-window sequencer: shift-add multiplies, restoring divides, square root
// ----------------------------------------------------------------------------
`default_nettype none

module wss_back #(
    parameter int SAMPLE_WIDTH       = wss_pkg::SAMPLE_WIDTH_DEF,
    parameter int WINDOW_COUNT_WIDTH = wss_pkg::WINDOW_COUNT_WIDTH_DEF
) (
    input  logic                                              aclk,
    input  logic                                              aresetn,
    input  logic                                              q_valid,
    output logic                                              q_pop,
    input  logic signed [SAMPLE_WIDTH+WINDOW_COUNT_WIDTH-1:0] q_sum,
    input  logic [2*SAMPLE_WIDTH+WINDOW_COUNT_WIDTH-3:0]      q_sumsq,
    input  logic signed [SAMPLE_WIDTH-1:0]                    q_min,
    input  logic signed [SAMPLE_WIDTH-1:0]                    q_max,
    input  logic [WINDOW_COUNT_WIDTH-1:0]                     q_count,
    output logic                                              m_valid,
    input  logic                                              m_ready,
    output logic signed [SAMPLE_WIDTH-1:0]                    m_mean,
    output logic signed [SAMPLE_WIDTH-1:0]                    m_minimum,
    output logic signed [SAMPLE_WIDTH-1:0]                    m_maximum,
    output logic [SAMPLE_WIDTH-1:0]                           m_std_dev
);

    localparam int SW   = SAMPLE_WIDTH;
    localparam int CW   = WINDOW_COUNT_WIDTH;
    localparam int SUMW = SW + CW;
    localparam int MAGW = SUMW - 1;
    localparam int SQW  = 2 * SW + CW - 2;
    localparam int NUMW = 2 * SW + 2 * CW - 2;
    localparam int CNTW = $clog2(NUMW + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_MULN,
        ST_SUB,
        ST_DIV1,
        ST_DIV2,
        ST_DIVM,
        ST_SQRT,
        ST_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [CNTW-1:0]    cnt_reg, cnt_next, cnt_dec;
    logic [CW-1:0]      n_reg, n_next;
    logic               neg_reg, neg_next;
    logic [MAGW-1:0]    mag_reg, mag_next;
    logic [SQW-1:0]     sq_reg, sq_next;
    logic [SW-1:0]      min_reg, min_next, max_reg, max_next;
    logic [MAGW-1:0]    mul_sh_reg, mul_sh_next;
    logic [NUMW-1:0]    acc_reg, acc_next, p_reg, p_next, dvd_reg, dvd_next;
    logic [CW-1:0]      rem_reg, rem_next, rem_step;
    logic [SW-1:0]      root_reg, root_next, root_step;
    logic [SW:0]        srem_reg, srem_next, srem_step;
    logic [SW-1:0]      mean_reg, mean_next;
    logic               out_valid_reg, out_valid_next;
    logic [SW-1:0]      out_mean_reg, out_mean_next, out_min_reg, out_min_next;
    logic [SW-1:0]      out_max_reg, out_max_next, out_sd_reg, out_sd_next;

    logic               last, div_ge, sq_ge, out_free;
    logic [SUMW-1:0]    sum_abs;
    logic [NUMW-1:0]    p_horner, acc_horner, num, dvd_step;
    logic [CW:0]        rem_sh, rem_sub;
    logic [MAGW-1:0]    quot_m, quot_neg;
    logic [SW+2:0]      srem_sh, trial, srem_sub;

    always_comb begin
        last     = (cnt_reg == CNTW'(1));
        cnt_dec  = cnt_reg - CNTW'(1);
        sum_abs  = q_sum[SUMW-1] ? -q_sum : q_sum;
        out_free = !out_valid_reg || m_ready;

        p_horner   = {p_reg[NUMW-2:0], 1'b0}
                   + (mul_sh_reg[MAGW-1] ? {{(NUMW-MAGW){1'b0}}, mag_reg} : '0);
        acc_horner = {acc_reg[NUMW-2:0], 1'b0}
                   + (mul_sh_reg[MAGW-1] ? {{(NUMW-SQW){1'b0}}, sq_reg} : '0);
        num        = acc_reg - p_reg;

        rem_sh   = {rem_reg, dvd_reg[NUMW-1]};
        div_ge   = (rem_sh >= {1'b0, n_reg});
        rem_sub  = rem_sh - {1'b0, n_reg};
        rem_step = div_ge ? rem_sub[CW-1:0] : rem_sh[CW-1:0];
        dvd_step = {dvd_reg[NUMW-2:0], div_ge};
        quot_m   = dvd_step[MAGW-1:0];
        quot_neg = -quot_m;

        srem_sh   = {srem_reg, p_reg[2*SW-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        sq_ge     = (srem_sh >= trial);
        srem_sub  = srem_sh - trial;
        srem_step = sq_ge ? srem_sub[SW:0] : srem_sh[SW:0];
        root_step = {root_reg[SW-2:0], sq_ge};
    end

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        n_next         = n_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        sq_next        = sq_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        mul_sh_next    = mul_sh_reg;
        acc_next       = acc_reg;
        p_next         = p_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        srem_next      = srem_reg;
        mean_next      = mean_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_mean_next  = out_mean_reg;
        out_min_next   = out_min_reg;
        out_max_next   = out_max_reg;
        out_sd_next    = out_sd_reg;
        q_pop          = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop       = 1'b1;
                    n_next      = q_count;
                    neg_next    = q_sum[SUMW-1];
                    mag_next    = sum_abs[MAGW-1:0];
                    mul_sh_next = sum_abs[MAGW-1:0];
                    sq_next     = q_sumsq;
                    min_next    = q_min;
                    max_next    = q_max;
                    p_next      = '0;
                    cnt_next    = CNTW'(MAGW);
                    state_next  = ST_SQ;
                end
            end
            // sum squared
            ST_SQ: begin
                p_next      = p_horner;
                mul_sh_next = {mul_sh_reg[MAGW-2:0], 1'b0};
                cnt_next    = cnt_dec;
                if (last) begin
                    mul_sh_next = {n_reg, {(MAGW-CW){1'b0}}};
                    acc_next    = '0;
                    cnt_next    = CNTW'(CW);
                    state_next  = ST_MULN;
                end
            end
            // count times sum of squares
            ST_MULN: begin
                acc_next    = acc_horner;
                mul_sh_next = {mul_sh_reg[MAGW-2:0], 1'b0};
                cnt_next    = cnt_dec;
                if (last) begin
                    state_next = ST_SUB;
                end
            end
            ST_SUB: begin
                dvd_next   = num;
                rem_next   = '0;
                cnt_next   = CNTW'(NUMW);
                state_next = ST_DIV1;
            end
            ST_DIV1: begin
                dvd_next = dvd_step;
                rem_next = rem_step;
                cnt_next = cnt_dec;
                if (last) begin
                    dvd_next   = {dvd_step[SQW-1:0], {(NUMW-SQW){1'b0}}};
                    rem_next   = '0;
                    cnt_next   = CNTW'(SQW);
                    state_next = ST_DIV2;
                end
            end
            ST_DIV2: begin
                dvd_next = dvd_step;
                rem_next = rem_step;
                cnt_next = cnt_dec;
                if (last) begin
                    p_next     = {{(NUMW-2*SW){1'b0}}, dvd_step[2*SW-1:0]};
                    dvd_next   = {mag_reg, {(NUMW-MAGW){1'b0}}};
                    rem_next   = '0;
                    cnt_next   = CNTW'(MAGW);
                    state_next = ST_DIVM;
                end
            end
            ST_DIVM: begin
                dvd_next = dvd_step;
                rem_next = rem_step;
                cnt_next = cnt_dec;
                if (last) begin
                    mean_next  = neg_reg ? quot_neg[SW-1:0] : quot_m[SW-1:0];
                    root_next  = '0;
                    srem_next  = '0;
                    cnt_next   = CNTW'(SW);
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                root_next = root_step;
                srem_next = srem_step;
                p_next    = {p_reg[NUMW-3:0], 2'b00};
                cnt_next  = cnt_dec;
                if (last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_mean_next  = mean_reg;
                    out_min_next   = min_reg;
                    out_max_next   = max_reg;
                    out_sd_next    = root_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        cnt_reg      <= cnt_next;
        n_reg        <= n_next;
        neg_reg      <= neg_next;
        mag_reg      <= mag_next;
        sq_reg       <= sq_next;
        min_reg      <= min_next;
        max_reg      <= max_next;
        mul_sh_reg   <= mul_sh_next;
        acc_reg      <= acc_next;
        p_reg        <= p_next;
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        root_reg     <= root_next;
        srem_reg     <= srem_next;
        mean_reg     <= mean_next;
        out_mean_reg <= out_mean_next;
        out_min_reg  <= out_min_next;
        out_max_reg  <= out_max_next;
        out_sd_reg   <= out_sd_next;
    end

    always_comb begin
        m_valid   = out_valid_reg;
        m_mean    = out_mean_reg;
        m_minimum = out_min_reg;
        m_maximum = out_max_reg;
        m_std_dev = out_sd_reg;
    end

endmodule

`default_nettype wire

@@ bench/tb_windowed_sample_statistics.sv @@
// ----------------------------------------------------------------------------
// tb_windowed_sample_statistics
// self-checking bench for the windowed sample statistics block: samples go in
// over a valid/ready channel with random gaps, window results come back under
// random back-pressure and are checked field by field against an exact
// integer prediction of mean, minimum, maximum and standard deviation. the
// window length is rewritten between phases, including zero, one and the
// largest length, and while a window is partly filled
// ----------------------------------------------------------------------------
module tb_windowed_sample_statistics;
    import wss_pkg::*;

    localparam int SW            = SAMPLE_WIDTH_DEF;
    localparam int SETTLE_CYCLES = 260;
    localparam int CYCLE_LIMIT   = 2_500_000;
    localparam int MAX_GAP       = 14;

    typedef struct {
        logic signed [SW-1:0] mean;
        logic signed [SW-1:0] minimum;
        logic signed [SW-1:0] maximum;
        logic [SW-1:0]        std_dev;
    } window_stats_t;

    class stats_scoreboard;
        logic [CFG_WIDTH-1:0] win_len;
        logic [CFG_WIDTH-1:0] position;
        longint               acc_sum;
        longint               acc_sq;
        logic signed [SW-1:0] low;
        logic signed [SW-1:0] high;
        window_stats_t        expected_q[$];
        int                   mismatches;

        function new();
            win_len    = WINDOW_LENGTH_RESET;
            position   = '0;
            acc_sum    = 0;
            acc_sq     = 0;
            low        = '0;
            high       = '0;
            mismatches = 0;
        endfunction

        function void set_length(logic [CFG_WIDTH-1:0] len);
            win_len = len;
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned rem_v;
            longint unsigned root;
            longint unsigned step;
            rem_v = v;
            root  = 0;
            step  = 64'h4000_0000_0000_0000;
            while (step > rem_v)
                step = step >> 2;
            while (step != 0) begin
                if (rem_v >= root + step) begin
                    rem_v = rem_v - (root + step);
                    root  = (root >> 1) + step;
                end else begin
                    root = root >> 1;
                end
                step = step >> 2;
            end
            return root;
        endfunction

        function void note_sample(logic signed [SW-1:0] smp);
            longint          eff;
            longint          cnt;
            longint          num;
            longint unsigned sd;
            window_stats_t   r;
            eff = (win_len == 0) ? 1 : longint'(win_len);
            if (position == 0) begin
                acc_sum = 0;
                acc_sq  = 0;
                low     = smp;
                high    = smp;
            end
            if (smp < low)
                low = smp;
            if (smp > high)
                high = smp;
            acc_sum  = acc_sum + longint'(smp);
            acc_sq   = acc_sq + longint'(smp) * longint'(smp);
            position = position + 1'b1;
            if (longint'(position) >= eff) begin
                cnt = longint'(position);
                num = acc_sq * cnt - acc_sum * acc_sum;
                sd  = int_sqrt(longint'(num / (cnt * cnt)));
                if (sd > 64'(2**SW - 1))
                    sd = 64'(2**SW - 1);
                r.mean    = SW'(acc_sum / cnt);
                r.minimum = low;
                r.maximum = high;
                r.std_dev = SW'(sd);
                expected_q.push_back(r);
                position = '0;
            end
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            mismatches++;
        endtask

        task check_window(window_stats_t got);
            window_stats_t want;
            if (expected_q.size() == 0) begin
                report($sformatf("result with no window pending, mean %0d", got.mean));
            end else begin
                want = expected_q.pop_front();
                if (got.mean !== want.mean)
                    report($sformatf("mean got %0d expected %0d", got.mean, want.mean));
                if (got.minimum !== want.minimum)
                    report($sformatf("minimum got %0d expected %0d",
                                     got.minimum, want.minimum));
                if (got.maximum !== want.maximum)
                    report($sformatf("maximum got %0d expected %0d",
                                     got.maximum, want.maximum));
                if (got.std_dev !== want.std_dev)
                    report($sformatf("std_dev got %0d expected %0d",
                                     got.std_dev, want.std_dev));
            end
        endtask
    endclass

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [CFG_WIDTH-1:0] cfg_wr_data = '0;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    logic signed [SW-1:0] s_sample    = '0;
    logic                 m_valid;
    logic                 m_ready     = 1'b0;
    logic signed [SW-1:0] m_mean;
    logic signed [SW-1:0] m_minimum;
    logic signed [SW-1:0] m_maximum;
    logic [SW-1:0]        m_std_dev;

    stats_scoreboard sb;
    int              cycle_count  = 0;
    bit              tx_burst     = 1'b0;
    bit              rx_burst     = 1'b0;
    int              ready_wait   = 0;
    int              result_count = 0;

    windowed_sample_statistics uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_sample   (s_sample),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_mean     (m_mean),
        .m_minimum  (m_minimum),
        .m_maximum  (m_maximum),
        .m_std_dev  (m_std_dev)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side: random stall before each transaction, with stall-free stretches
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            ready_wait <= 0;
        end else if (m_valid && m_ready) begin
            sb.check_window('{m_mean, m_minimum, m_maximum, m_std_dev});
            result_count <= result_count + 1;
            if (result_count % 16 == 0)
                rx_burst <= ($urandom_range(0, 2) == 0);
            if (!rx_burst) begin
                ready_wait <= $urandom_range(0, MAX_GAP);
                m_ready    <= 1'b0;
            end
        end else if (!m_ready) begin
            if (ready_wait == 0)
                m_ready <= 1'b1;
            else
                ready_wait <= ready_wait - 1;
        end
    end

    task automatic send(input int value);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= value[SW-1:0];
        do @(posedge aclk); while (!s_ready);
        sb.note_sample(value[SW-1:0]);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_length(input int len);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len[CFG_WIDTH-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_length(len[CFG_WIDTH-1:0]);
    endtask

    function automatic int draw_sample();
        case ($urandom_range(0, 7))
            0:       return -32768;
            1:       return 32767;
            2, 3:    return int'($urandom_range(0, 31)) - 16;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    initial begin
        int reset_window[$] = '{-32768, 32767, 0, -1, 1, 21845, -21846, 255,
                                -256, 1000, -1000, 32767, -32768, 12345, -12345, 7};
        int phase_len[$]    = '{1, 3, 2, 7, 0, 16, 33, 4, 100, 1, 5, 65535, 2};
        int items;
        sb = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset length, single-sample windows, zero length, extremes
        foreach (reset_window[i])
            send(reset_window[i]);
        write_length(1);
        send(-32768);
        send(32767);
        write_length(0);
        send(12345);
        write_length(2);
        send(-32768);
        send(32767);
        // shorten the window after three samples: next transaction closes it at four
        write_length(5);
        send(-5);
        send(300);
        send(-32768);
        write_length(2);
        send(32767);

        // random phases; most leave a window partly filled across the length change
        foreach (phase_len[p]) begin
            write_length(phase_len[p]);
            items = (phase_len[p] > 200) ? 40 : $urandom_range(70, 140);
            for (int i = 0; i < items; i++) begin
                if (i % 32 == 0)
                    tx_burst = ($urandom_range(0, 3) == 0);
                send(draw_sample());
            end
        end
        tx_burst = 1'b0;

        drain();
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

@@ files.f @@
+incdir+sv
sv/wss_pkg.sv
sv/wss_fifo.sv
sv/wss_front.sv
sv/wss_back.sv
sv/windowed_sample_statistics.sv
bench/tb_windowed_sample_statistics.sv
